@@ rtl/deq_pkg.sv @@
// shared types and codes for the double-ended queue
package deq_pkg;

   localparam int DATA_W = 16;
   localparam int POS_W  = 7;
   localparam int CNT_W  = 7;

   // operation codes carried in the kind field
   localparam logic [2:0] K_PUSH_FRONT = 3'd0;
   localparam logic [2:0] K_PUSH_BACK  = 3'd1;
   localparam logic [2:0] K_POP_FRONT  = 3'd2;
   localparam logic [2:0] K_POP_BACK   = 3'd3;
   localparam logic [2:0] K_READ       = 3'd4;
   localparam logic [2:0] K_QUERY      = 3'd5;

   // error codes
   localparam logic [1:0] E_OK    = 2'd0;
   localparam logic [1:0] E_EMPTY = 2'd1;
   localparam logic [1:0] E_FULL  = 2'd2;
   localparam logic [1:0] E_RANGE = 2'd3;

   typedef struct packed {
      logic [2:0]              kind;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]        position;
   } deq_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_W-1:0]        count;
      logic                    empty_res;
      logic [1:0]              error;
   } deq_rsp_type;

endpackage

@@ rtl/double_ended_queue.sv @@
// double-ended queue top level: ring buffer control around the element store
// pushes, queries, errors and pops that empty the queue need no store read;
// result registered in the cycle after the request beat
// pops that leave elements and position reads wait in a store read state, taking
// no new request, since the new front/back or the read element comes from the one store read port
// synchronous reset empties the queue; store contents are not cleared
module double_ended_queue #(
   parameter int DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  deq_pkg::deq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_rsp_type rsp_data
);
   import deq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam logic [AW:0]    DEPTH_S = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0]  LAST_SLOT = AW'(DEPTH - 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RD   = 1'b1;

   localparam logic [1:0] T_FRONT = 2'd0;
   localparam logic [1:0] T_BACK  = 2'd1;
   localparam logic [1:0] T_READ  = 2'd2;

   logic              state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] front_ff, front_in;
   logic [DATA_W-1:0] back_ff, back_in;
   logic [1:0]        tgt_ff, tgt_in;
   deq_rsp_type       rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic              out_free;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic [DATA_W-1:0] rd_val;
   logic [1:0]        err;
   logic [AW-1:0]     head_dec;
   logic [CW-1:0]     cnt_m1, cnt_m2;
   logic [XW-1:0]     pos_ext, cnt_ext, pos_m1;
   logic              full, empty;

   // ring slot at an offset from the given head
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] off);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, off};
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[AW-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign full     = (count_ff == DEPTH_C);
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_m2   = count_ff - CW'(2);
   assign pos_ext  = XW'(req_data.position);
   assign cnt_ext  = XW'(count_ff);
   assign pos_m1   = pos_ext - XW'(1);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      tgt_in       = tgt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = head_dec;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      rd_val       = '0;
      err          = E_OK;

      if (accept) begin
         case (req_data.kind)
            K_PUSH_FRONT: begin
               if (full) begin
                  err = E_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CW'(1);
                  front_in = req_data.value;
                  if (empty) begin
                     back_in = req_data.value;
                  end
               end
            end
            K_PUSH_BACK: begin
               if (full) begin
                  err = E_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = slot(head_ff, count_ff[AW-1:0]);
                  count_in = count_ff + CW'(1);
                  back_in  = req_data.value;
                  if (empty) begin
                     front_in = req_data.value;
                  end
               end
            end
            K_POP_FRONT: begin
               if (empty) begin
                  err = E_EMPTY;
               end else begin
                  rd_val   = front_ff;
                  head_in  = slot(head_ff, AW'(1));
                  count_in = cnt_m1;
                  // new front comes from the store
                  if (count_ff != CW'(1)) begin
                     rd_en   = 1'b1;
                     rd_addr = slot(head_ff, AW'(1));
                     tgt_in  = T_FRONT;
                  end
               end
            end
            K_POP_BACK: begin
               if (empty) begin
                  err = E_EMPTY;
               end else begin
                  rd_val   = back_ff;
                  count_in = cnt_m1;
                  if (count_ff != CW'(1)) begin
                     rd_en   = 1'b1;
                     rd_addr = slot(head_ff, cnt_m2[AW-1:0]);
                     tgt_in  = T_BACK;
                  end
               end
            end
            K_READ: begin
               if (pos_ext == '0 || pos_ext > cnt_ext) begin
                  err = E_RANGE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = slot(head_ff, pos_m1[AW-1:0]);
                  tgt_in  = T_READ;
               end
            end
            default: begin
            end
         endcase

         if (rd_en) begin
            state_in = S_RD;
         end else begin
            rsp_valid_in       = 1'b1;
            rsp_in.front_value = (count_in == '0) ? '0 : front_in;
            rsp_in.back_value  = (count_in == '0) ? '0 : back_in;
            rsp_in.read_value  = rd_val;
            rsp_in.count       = CNT_W'(count_in);
            rsp_in.empty_res   = (count_in == '0);
            rsp_in.error       = err;
         end
      end else if (state_ff == S_RD && out_free) begin
         // store data is back: finish the beat
         if (tgt_ff == T_FRONT) begin
            front_in = rd_data;
         end
         if (tgt_ff == T_BACK) begin
            back_in = rd_data;
         end
         if (tgt_ff == T_READ) begin
            rd_val = rd_data;
         end else begin
            rd_val = rsp_ff.read_value;
         end
         state_in           = S_IDLE;
         rsp_valid_in       = 1'b1;
         rsp_in.front_value = front_in;
         rsp_in.back_value  = back_in;
         rsp_in.read_value  = rd_val;
         rsp_in.count       = CNT_W'(count_ff);
         rsp_in.empty_res   = 1'b0;
         rsp_in.error       = E_OK;
      end
   end

   // popped value is parked in the result register until the store read returns
   always_ff @(posedge clock) begin
      if (accept && rd_en) begin
         rsp_ff.read_value <= rd_val;
      end else begin
         rsp_ff <= rsp_in;
      end
      front_ff <= front_in;
      back_ff  <= back_in;
      tgt_ff   <= tgt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   deq_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_data.value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("element count above depth");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, head_ff} < DEPTH_S)
      else $error("head index outside ring");

   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> !req_ready)
      else $error("request taken while store read pending");

   a_read_completes: assert property (@(posedge clock) disable iff (reset)
      accept && rd_en |=> state_ff == S_RD && !rsp_valid_ff)
      else $error("store read issued with result register busy");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.kind == K_PUSH_FRONT || req_data.kind == K_PUSH_BACK) && !full
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the queue");
`endif

endmodule

@@ rtl/deq_ram.sv @@
// element store: one write port, one read port with registered read data
module deq_ram #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [deq_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [deq_pkg::DATA_W-1:0] rd_data
);
   import deq_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
